/* src/swfp_pkg.sv */
`timescale 1ns / 1ps
// swfp_pkg: constants and types shared by the serial wheel frame parser
// depends on nothing; used by swfp_assembler, the top and both sim files

package swfp_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hFA;
    localparam logic [7:0] HDR_SECOND = 8'hAF;
    localparam logic [7:0] TRAILER    = 8'hED;

    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(15);
    localparam logic [POS_W-1:0] DROP_POS  = POS_W'(16);
    localparam int PAY_FIRST = 2;
    localparam int PAY_LAST  = 14;

    typedef struct packed {
        logic [15:0] vel_left_back;
        logic [15:0] vel_left_front;
        logic [15:0] vel_right_back;
        logic [15:0] vel_right_front;
        logic [7:0]  io_bits;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } frame_t;

endpackage

/* src/serial_wheel_frame_parser_top.sv */
`timescale 1ns / 1ps
// serial_wheel_frame_parser_top: byte stream in, decoded wheel frame out
// depends on swfp_pkg and swfp_assembler
//
// input channel: one received serial byte per beat on rx_byte (in_valid/in_ready)
// output channel: one beat per completed frame (out_valid/out_ready) carrying
//   four wheel velocities, io_bits, pos_x and pos_y, all big-endian unsigned
// a frame is 0xFA 0xAF, 13 payload bytes, then 0xED at position 15; a bad
//   trailer makes the next byte get dropped and the hunt restart
// throughput: one byte per cycle while in_ready is high, with a combinational
//   compare in front of the result register
// latency: the result beat is valid the cycle after the trailer beat is taken
// reset clears the hunt state and the result valid flag; payload storage and
//   result data are not cleared, and payload is always rewritten before any
//   frame is reported
// when the receiver stalls with a result pending, the result holds and in_ready
//   drops; it stays low while a result waits and out_ready is low, and goes
//   high again in the cycle the result is taken

module serial_wheel_frame_parser_top
    import swfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] vel_left_back,
    output logic [15:0] vel_left_front,
    output logic [15:0] vel_right_back,
    output logic [15:0] vel_right_front,
    output logic [7:0]  io_bits,
    output logic [15:0] pos_x,
    output logic [15:0] pos_y
);

    logic   beat;
    logic   frame_done;
    frame_t frame;
    logic   out_valid_reg;
    frame_t frame_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign beat     = in_valid && in_ready;

    swfp_assembler u_assembler (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .rx_byte    (rx_byte),
        .frame_done (frame_done),
        .frame      (frame)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (frame_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            frame_reg <= frame;
        end
    end

    assign out_valid       = out_valid_reg;
    assign vel_left_back   = frame_reg.vel_left_back;
    assign vel_left_front  = frame_reg.vel_left_front;
    assign vel_right_back  = frame_reg.vel_right_back;
    assign vel_right_front = frame_reg.vel_right_front;
    assign io_bits         = frame_reg.io_bits;
    assign pos_x           = frame_reg.pos_x;
    assign pos_y           = frame_reg.pos_y;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !frame_done)
        else $error("pending result overwritten");

    a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> out_valid_reg)
        else $error("completed frame not reported");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(frame_done))
        else $error("result raised without a completed frame");

endmodule

/* src/swfp_assembler.sv */
`timescale 1ns / 1ps
// swfp_assembler: header hunt, byte position tracking and payload storage
// depends on swfp_pkg

module swfp_assembler
    import swfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       beat,
    input  logic [7:0] rx_byte,
    output logic       frame_done,
    output frame_t     frame
);

    logic             saw_first_reg;
    logic             saw_second_reg;
    logic [POS_W-1:0] pos_reg;
    logic             saw_first_next;
    logic             saw_second_next;
    logic [POS_W-1:0] pos_next;
    logic             in_frame;
    logic [7:0]       store_reg [PAY_FIRST:PAY_LAST];

    assign in_frame   = saw_first_reg && saw_second_reg;
    assign frame_done = beat && in_frame && (pos_reg == LAST_POS) && (rx_byte == TRAILER);

    always_comb
    begin
        saw_first_next  = saw_first_reg;
        saw_second_next = saw_second_reg;
        pos_next        = pos_reg;
        if (beat)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (in_frame)
            begin
                if (frame_done || (pos_reg == DROP_POS))
                begin
                    saw_first_next  = 1'b0;
                    saw_second_next = 1'b0;
                    pos_next        = '0;
                end
            end
            else if ((rx_byte == HDR_FIRST) && !saw_first_reg)
            begin
                saw_first_next = 1'b1;
            end
            else if ((rx_byte == HDR_SECOND) && saw_first_reg && !saw_second_reg)
            begin
                saw_second_next = 1'b1;
            end
            else
            begin
                saw_first_next  = 1'b0;
                saw_second_next = 1'b0;
                pos_next        = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saw_first_reg  <= 1'b0;
            saw_second_reg <= 1'b0;
            pos_reg        <= '0;
        end
        else
        begin
            saw_first_reg  <= saw_first_next;
            saw_second_reg <= saw_second_next;
            pos_reg        <= pos_next;
        end
    end

    // payload bytes only; header and trailer are never read back
    always_ff @(posedge clk)
    begin
        for (int i = PAY_FIRST; i <= PAY_LAST; i++)
        begin
            if (beat && (pos_reg == POS_W'(i)))
            begin
                store_reg[i] <= rx_byte;
            end
        end
    end

    assign frame.vel_left_back   = {store_reg[2],  store_reg[3]};
    assign frame.vel_left_front  = {store_reg[4],  store_reg[5]};
    assign frame.vel_right_back  = {store_reg[6],  store_reg[7]};
    assign frame.vel_right_front = {store_reg[8],  store_reg[9]};
    assign frame.io_bits         = store_reg[10];
    assign frame.pos_x           = {store_reg[11], store_reg[12]};
    assign frame.pos_y           = {store_reg[13], store_reg[14]};

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= DROP_POS)
        else $error("byte position past drop slot");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        saw_second_reg |-> saw_first_reg)
        else $error("second header flag without first");

    a_hunt_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !saw_second_reg |-> (pos_reg == POS_W'(saw_first_reg)))
        else $error("position out of step with header hunt");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> (!saw_first_reg && (pos_reg == '0)))
        else $error("parser did not return to hunting after a frame");

endmodule

/* sim/serial_wheel_frame_checker.sv */
`timescale 1ns / 1ps
// serial_wheel_frame_checker: watches both beats of the frame parser, predicts
// each decoded frame from the byte stream and compares it against the output
// depends on swfp_pkg

module serial_wheel_frame_checker
    import swfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] vel_left_back,
    input  logic [15:0] vel_left_front,
    input  logic [15:0] vel_right_back,
    input  logic [15:0] vel_right_front,
    input  logic [7:0]  io_bits,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    output int          mismatches,
    output int          frames_pending
);

    logic             got_first = 1'b0;
    logic             got_second = 1'b0;
    logic [POS_W-1:0] next_pos = '0;
    logic [7:0]       frame_bytes [16];
    frame_t           frames_due [$];

    initial
    begin
        mismatches = 0;
        frames_pending = 0;
        foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    end

    function automatic logic [15:0] word_at(int hi);
        return {frame_bytes[hi], frame_bytes[hi + 1]};
    endfunction

    task automatic restart_hunt();
        got_first = 1'b0;
        got_second = 1'b0;
        next_pos = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [POS_W-1:0] pos;
        frame_t           f;
        pos = next_pos;
        if (pos <= LAST_POS)
            frame_bytes[pos[3:0]] = b;
        next_pos = pos + 1'b1;
        if (got_first && got_second)
        begin
            if (pos == LAST_POS && b == TRAILER)
            begin
                f.vel_left_back   = word_at(2);
                f.vel_left_front  = word_at(4);
                f.vel_right_back  = word_at(6);
                f.vel_right_front = word_at(8);
                f.io_bits         = frame_bytes[10];
                f.pos_x           = word_at(11);
                f.pos_y           = word_at(13);
                frames_due.push_back(f);
                restart_hunt();
            end
            else if (pos > LAST_POS)
                restart_hunt();
        end
        else if (b == HDR_FIRST && !got_first)
            got_first = 1'b1;
        else if (b == HDR_SECOND && got_first && !got_second)
            got_second = 1'b1;
        else
            restart_hunt();
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (want !== seen)
        begin
            $error("%s expected %h actual %h", name, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        frame_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("frame beat with no frame expected");
                    mismatches++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("vel_left_back", want.vel_left_back, vel_left_back);
                    check_field("vel_left_front", want.vel_left_front, vel_left_front);
                    check_field("vel_right_back", want.vel_right_back, vel_right_back);
                    check_field("vel_right_front", want.vel_right_front, vel_right_front);
                    check_field("io_bits", {8'h00, want.io_bits}, {8'h00, io_bits});
                    check_field("pos_x", want.pos_x, pos_x);
                    check_field("pos_y", want.pos_y, pos_y);
                end
            end
            if (in_valid && in_ready)
                parse_byte(rx_byte);
            frames_pending = frames_due.size();
        end
    end

endmodule

/* sim/serial_wheel_frame_parser_top_test.sv */
`timescale 1ns / 1ps
// serial_wheel_frame_parser_top_test: drives byte streams of good, broken and
// noisy frames into the parser under varying idle and stall, and gives the verdict
// depends on swfp_pkg, serial_wheel_frame_parser_top and serial_wheel_frame_checker

module serial_wheel_frame_parser_top_test;
    import swfp_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int PHASE_BYTES = 150;
    localparam int NUM_PHASES  = 8;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] vel_left_back;
    logic [15:0] vel_left_front;
    logic [15:0] vel_right_back;
    logic [15:0] vel_right_front;
    logic [7:0]  io_bits;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    int          mismatches;
    int          frames_pending;

    int idle_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    int stuck = 0;
    int idle_set [NUM_PHASES]  = '{0, 71, 0, 22, 0, 71, 0, 22};
    int stall_set [NUM_PHASES] = '{0, 0, 71, 22, 0, 0, 71, 22};

    serial_wheel_frame_parser_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .vel_left_back   (vel_left_back),
        .vel_left_front  (vel_left_front),
        .vel_right_back  (vel_right_back),
        .vel_right_front (vel_right_front),
        .io_bits         (io_bits),
        .pos_x           (pos_x),
        .pos_y           (pos_y)
    );

    serial_wheel_frame_checker frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .vel_left_back   (vel_left_back),
        .vel_left_front  (vel_left_front),
        .vel_right_back  (vel_right_back),
        .vel_right_front (vel_right_front),
        .io_bits         (io_bits),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .mismatches      (mismatches),
        .frames_pending  (frames_pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= STUCK_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic drain_frames();
        in_valid <= 1'b0;
        @(negedge clk);
        while (frames_pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return HDR_FIRST;
            3: return HDR_SECOND;
            4: return TRAILER;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_frame(input bit bad_trailer, input logic [7:0] fill,
                              input bit use_fill);
        logic [7:0] last;
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        for (int i = PAY_FIRST; i <= PAY_LAST; i++)
            send_byte(use_fill ? fill : payload_byte());
        if (bad_trailer)
        begin
            do
                last = 8'($urandom);
            while (last == TRAILER);
            send_byte(last);
            send_byte(payload_byte());
        end
        else
            send_byte(TRAILER);
    endtask

    initial
    begin
        int phase_start;
        int noise;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // repeated header start clears the hunt
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        // all ones payload, then payload with a trailer value inside it
        send_frame(1'b0, 8'hFF, 1'b1);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        for (int i = PAY_FIRST; i <= PAY_LAST; i++)
            send_byte(i == 7 ? TRAILER : 8'h00);
        send_byte(TRAILER);
        // bad trailer; the header start right after it is dropped
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        for (int i = PAY_FIRST; i <= LAST_POS; i++)
            send_byte(8'h00);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_frame(1'b0, 8'h00, 1'b1);
        drain_frames();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                if ($urandom_range(0, 99) < 20)
                begin
                    noise = $urandom_range(1, 3);
                    repeat (noise)
                        send_byte($urandom_range(0, 3) == 0 ? HDR_FIRST : 8'($urandom));
                end
                send_frame($urandom_range(0, 99) < 15, 8'h00, 1'b0);
            end
            drain_frames();
        end

        idle_pct = 0;
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
